FILE: rtl/fqir_pkg.sv
package fqir_pkg;

  // Queue geometry.
  localparam int DEPTH      = 16;
  localparam int ELEM_WIDTH = 32;

  // Field widths of the channels.
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 5;

  // Width used when a position is compared with the entry count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [0:0] {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_t;

  // One request beat.
  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } fqir_req_t;

  // One result beat.
  typedef struct packed {
    logic signed [VALUE_W-1:0] head_value;
    logic                      is_empty;
    logic [OUT_CNT_W-1:0]      entry_count;
    status_t                   status;
  } fqir_result_t;

endpackage

FILE: rtl/fqir_if.sv
// Request channel: one queue operation per beat.
interface fqir_req_if import fqir_pkg::*; ();
  logic                      valid;
  logic                      ready;
  op_t                       op;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, op, value, position, input ready);
  modport sink   (input valid, op, value, position, output ready);
endinterface

// Response channel: one queue snapshot per beat.
interface fqir_rsp_if import fqir_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] head_value;
  logic                      is_empty;
  logic [OUT_CNT_W-1:0]      entry_count;
  status_t                   status;

  modport source (output valid, head_value, is_empty, entry_count, status, input ready);
  modport sink   (input valid, head_value, is_empty, entry_count, status, output ready);
endinterface

FILE: rtl/fifo_queue_with_indexed_removal_top.sv
// Bounded FIFO queue of signed words with removal at any position.
//
// Request channel (req): op selects append (value goes to the tail) or
// removal of the entry at position, counted from the head; position 0 is
// a plain dequeue. Entries behind a removed one close up the gap.
// Response channel (rsp): one beat per request with the head value (0 when
// empty), an empty flag, the entry count and a status: done, full on
// append, or position not below the count. Failed operations change nothing.
//
// The response beat appears in the cycle after its request is accepted.
// Throughput is one request per cycle while rsp.ready stays high: the queue
// is a row of registers with a shift multiplexer per entry, so any operation
// completes in the cycle it is accepted and the result register holds the
// snapshot. Reset empties the queue and clears the response valid flag.
// When the receiver stalls, the response beat is held and req.ready drops
// until it is taken; the result register is released and refilled in the
// same cycle, so no bubble appears while rsp.ready stays high.
module fifo_queue_with_indexed_removal_top import fqir_pkg::*; (
  input logic        clk,
  input logic        rst,
  fqir_req_if.sink   req,
  fqir_rsp_if.source rsp
);

  fqir_req_t    req_beat;
  fqir_result_t result;
  logic         can_take;
  logic         take;

  assign req_beat.op       = req.op;
  assign req_beat.value    = req.value;
  assign req_beat.position = req.position;

  assign req.ready = can_take;
  assign take      = req.valid && can_take;

  fqir_store u_store (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .req    (req_beat),
    .result (result)
  );

  fqir_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .result   (result),
    .can_take (can_take),
    .rsp      (rsp)
  );

endmodule

FILE: rtl/fqir_store.sv
module fqir_store import fqir_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  fqir_req_t    req,
  output fqir_result_t result
);

  elem_t   entries [DEPTH];
  elem_t   entries_next [DEPTH];
  count_t  count;
  count_t  count_next;
  status_t status;

  logic [63:0]       value_wide;
  elem_t             value_elem;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              full;
  logic [63:0]       head_wide;

  // Sign-extend the incoming word and cut it to the stored width.
  assign value_wide = {{(64 - VALUE_W){req.value[VALUE_W-1]}}, req.value};
  assign value_elem = value_wide[ELEM_WIDTH-1:0];
  assign pos_c      = CMP_W'(req.position);
  assign cnt_c      = CMP_W'(count);
  assign full       = (count == CNT_W'(DEPTH));

  // Per-entry update: write at the tail, or shift the entries behind a removal up by one.
  always_comb begin
    entries_next = entries;
    count_next   = count;
    status       = ST_DONE;
    if (req.op == OP_APPEND) begin
      if (full) begin
        status = ST_FULL;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CNT_W'(i) == count) begin
            entries_next[i] = value_elem;
          end
        end
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (pos_c >= cnt_c) begin
        status = ST_BAD_POS;
      end else begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if ((CMP_W'(i) >= pos_c) && (CMP_W'(i + 1) < cnt_c)) begin
            entries_next[i] = entries[i + 1];
          end
        end
        count_next = count - CNT_W'(1);
      end
    end
  end

  // Entry storage needs no reset; only entries below the count are ever read.
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= entries_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      count <= count_next;
    end
  end

  // Snapshot of the queue after this operation.
  assign head_wide = 64'(entries_next[0]);

  always_comb begin
    result.head_value  = (count_next == '0) ? '0 : head_wide[VALUE_W-1:0];
    result.is_empty    = (count_next == '0);
    result.entry_count = OUT_CNT_W'(count_next);
    result.status      = status;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above queue depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (take && req.op == OP_APPEND && full) |=> (count == $past(count)))
    else $error("append to a full queue changed the count");

  a_bad_pos_holds: assert property (@(posedge clk) disable iff (rst)
    (take && req.op == OP_REMOVE && pos_c >= cnt_c) |=> (count == $past(count)))
    else $error("removal at an invalid position changed the count");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    (take && req.op == OP_REMOVE && pos_c < cnt_c) |=> (count == $past(count) - CNT_W'(1)))
    else $error("valid removal did not drop the count by one");
`endif

endmodule

FILE: rtl/fqir_out_reg.sv
module fqir_out_reg import fqir_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  fqir_result_t result,
  output logic         can_take,
  fqir_rsp_if.source   rsp
);

  logic         valid;
  fqir_result_t data;

  // A new beat may enter when the register is empty or being drained this cycle.
  assign can_take = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_take) begin
      data <= result;
    end
  end

  // Drive the response channel from the register.
  assign rsp.valid       = valid;
  assign rsp.head_value  = data.head_value;
  assign rsp.is_empty    = data.is_empty;
  assign rsp.entry_count = data.entry_count;
  assign rsp.status      = data.status;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (valid && !rsp.ready) |-> !(load && can_take))
    else $error("result register overwritten while stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load && can_take) |=> valid)
    else $error("loaded result not presented");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    valid |-> (data.is_empty == (data.entry_count == '0)))
    else $error("empty flag disagrees with entry count");
`endif

endmodule

FILE: dv/tb_fifo_queue_with_indexed_removal_top.sv
`timescale 1ns / 100ps

module tb_fifo_queue_with_indexed_removal_top import fqir_pkg::*;;

  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 200000;

  // Tracks the queue contents and holds the snapshots the block should report.
  class fqir_queue_mirror;
    elem_t        slots[DEPTH];
    int unsigned  held;
    fqir_result_t expected_snapshots[$];
    int           mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    // Applies one accepted request beat and queues the snapshot it must produce.
    function void note_request(op_t op, logic signed [VALUE_W-1:0] value,
                               logic [POS_W-1:0] position);
      status_t      st;
      fqir_result_t snap;
      int unsigned  i;
      st = ST_DONE;
      if (op == OP_APPEND) begin
        if (held >= DEPTH) begin
          st = ST_FULL;
        end else begin
          slots[held] = elem_t'(value);
          held++;
        end
      end else if (position >= held) begin
        st = ST_BAD_POS;
      end else begin
        // Entries behind the removed one move up by one place.
        for (i = position; i + 1 < held; i++) begin
          slots[i] = slots[i + 1];
        end
        held--;
      end
      snap.head_value  = (held > 0) ? slots[0][VALUE_W-1:0] : '0;
      snap.is_empty    = (held == 0);
      snap.entry_count = held[OUT_CNT_W-1:0];
      snap.status      = st;
      expected_snapshots.push_back(snap);
    endfunction

    // Compares one accepted response beat with the oldest outstanding snapshot.
    function void check_snapshot(logic signed [VALUE_W-1:0] head_value, logic is_empty,
                                 logic [OUT_CNT_W-1:0] entry_count, status_t status);
      fqir_result_t snap;
      logic signed [VALUE_W-1:0] exp_head;
      if (expected_snapshots.size() == 0) begin
        $error("response beat with no request outstanding");
        mismatches++;
        return;
      end
      snap     = expected_snapshots.pop_front();
      exp_head = snap.head_value;
      if (head_value !== exp_head) begin
        $error("head_value: expected %0d, got %0d", exp_head, head_value);
        mismatches++;
      end
      if (is_empty !== snap.is_empty) begin
        $error("is_empty: expected %0b, got %0b", snap.is_empty, is_empty);
        mismatches++;
      end
      if (entry_count !== snap.entry_count) begin
        $error("entry_count: expected %0d, got %0d", snap.entry_count, entry_count);
        mismatches++;
      end
      if (status !== snap.status) begin
        $error("status: expected %0d, got %0d", snap.status, status);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_snapshots.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet_stretch;
  int   cycles;

  fqir_queue_mirror mirror;

  fqir_req_if req_chan ();
  fqir_rsp_if rsp_chan ();

  fifo_queue_with_indexed_removal_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_chan),
    .rsp (rsp_chan)
  );

  // Clock and cycle limit.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Random gap with a chance of 11 in a hundred, except in the quiet stretch.
  function automatic bit take_gap();
    return !quiet_stretch && ($urandom_range(0, 99) < 11);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2:       return VALUE_W'($signed($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Receiver stalls at random; ready changes on the falling edge.
  always @(negedge clk) begin
    rsp_chan.ready = !take_gap();
  end

  // Both channels are observed at the rising edge, requests before responses.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_chan.valid && req_chan.ready) begin
        mirror.note_request(req_chan.op, req_chan.value, req_chan.position);
      end
      if (rsp_chan.valid && rsp_chan.ready) begin
        mirror.check_snapshot(rsp_chan.head_value, rsp_chan.is_empty,
                              rsp_chan.entry_count, rsp_chan.status);
      end
    end
  end

  // Drives one request beat; entered and left at a falling edge.
  task automatic send_request(input op_t op, input logic signed [VALUE_W-1:0] value,
                              input logic [POS_W-1:0] position);
    while (take_gap()) begin
      req_chan.valid = 1'b0;
      @(negedge clk);
    end
    req_chan.valid    = 1'b1;
    req_chan.op       = op;
    req_chan.value    = value;
    req_chan.position = position;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int          n;
    int          bias;
    int          append_pct;
    int unsigned held_now;
    op_t         op;
    logic [POS_W-1:0] pos;

    mirror            = new();
    cycles            = 0;
    quiet_stretch     = 1'b0;
    rst               = 1'b1;
    req_chan.valid    = 1'b0;
    req_chan.op       = OP_APPEND;
    req_chan.value    = '0;
    req_chan.position = '0;
    rsp_chan.ready    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: removal from an empty queue, extreme values, filling up,
    // append when full, removal of the tail, bad position, middle and head.
    send_request(OP_REMOVE, '0, 4'd0);
    send_request(OP_REMOVE, -1, 4'd15);
    send_request(OP_APPEND, {1'b1, {(VALUE_W-1){1'b0}}}, 4'd0);
    send_request(OP_APPEND, {1'b0, {(VALUE_W-1){1'b1}}}, 4'd15);
    send_request(OP_APPEND, '0, 4'd0);
    send_request(OP_APPEND, -1, 4'd0);
    send_request(OP_APPEND, 32'h5555_5555, 4'd0);
    send_request(OP_APPEND, 32'hAAAA_AAAA, 4'd0);
    for (n = 6; n < DEPTH; n++) begin
      send_request(OP_APPEND, $urandom, 4'($urandom_range(0, 15)));
    end
    send_request(OP_APPEND, 32'h1234_5678, 4'd0);
    send_request(OP_REMOVE, $urandom, 4'd15);
    send_request(OP_REMOVE, $urandom, 4'd15);
    send_request(OP_REMOVE, $urandom, 4'd7);
    send_request(OP_REMOVE, $urandom, 4'd0);
    send_request(OP_APPEND, -2, 4'd3);

    // Random part: phases that lean towards filling, draining or balance, so
    // that every fill level is visited; removals mostly hit a held entry.
    bias = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        bias = $urandom_range(0, 2);
      end
      quiet_stretch = (n >= 400 && n < 600);
      held_now      = mirror.held;
      append_pct    = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
      op  = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_REMOVE;
      pos = 4'($urandom_range(0, 15));
      if (op == OP_REMOVE && held_now > 0 && $urandom_range(0, 99) < 85) begin
        pos = 4'($urandom_range(0, held_now - 1));
      end
      send_request(op, pick_value(), pos);
    end
    req_chan.valid = 1'b0;
    quiet_stretch  = 1'b0;

    // Wait for every response beat, then for any stray beats.
    while (mirror.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
